@@ src/assert_macros.svh @@
// Assertion helpers used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define VWD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition on one edge implies a property on the next edge
`define VWD_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ src/vwd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex weld package
// Sizes, codes, state encoding and control structs of the weld table.
// ----------------------------------------------------------------------------
package vwd_pkg;

    localparam int TABLE_SLOTS   = 8192;
    localparam int MAX_VERTICES  = 4096;
    localparam int MAX_KEY_WORDS = 16;

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int VTX_W  = $clog2(MAX_VERTICES);
    localparam int CNT_W  = VTX_W + 1;
    localparam int WPOS_W = $clog2(MAX_KEY_WORDS);
    localparam int KW_W   = WPOS_W + 1;
    localparam int KADR_W = SLOT_W + WPOS_W;
    localparam int CLR_W  = SLOT_W + 1;

    localparam logic [31:0] MIX_M = 32'h5bd1e995;
    localparam int          MIX_R = 24;

    localparam logic [1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [1:0] CFG_TABLE_BITS   = 2'd1;
    localparam logic [1:0] CFG_KEY_WORDS    = 2'd2;

    localparam logic ACT_WORD  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    localparam logic [2:0] ST_NEW    = 3'd0;
    localparam logic [2:0] ST_MATCH  = 3'd1;
    localparam logic [2:0] ST_REPEAT = 3'd2;
    localparam logic [2:0] ST_RANGE  = 3'd3;
    localparam logic [2:0] ST_FULL   = 3'd4;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_LOOKUP,
        S_REMAP_CHK,
        S_META_RD,
        S_META_CHK,
        S_KEY_RD,
        S_KEY_CHK,
        S_COPY,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic start;
        logic last;
        logic clear;
    } hash_ctl_t;

    typedef struct packed {
        logic done;
    } hash_stat_t;

endpackage

@@ src/vertex_weld_dedup_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex weld dedup table
// Hashes each index entry's key words, probes an open-addressed slot table
// and returns the welded vertex index once per entry.
// ----------------------------------------------------------------------------
// Steps: each key word runs through the shared hash multiplier; the last
//   word adds a range check, a remap lookup, a read and check per probed
//   slot plus a read and check per compared key word, or a key copy, then the result.
// Flow: one item at a time; input stalls until the current word is done.
// Reset and clear: a sweep over the slot and remap memories,
//   one entry a cycle; input stalls meanwhile, configuration is still taken.
module vertex_weld_dedup_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [15:0] src_index,
    input  logic [31:0] key_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] out_index,
    output logic [2:0]  status,
    output logic [12:0] unique_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);
    import vwd_pkg::*;

    state_t state_reg, state_next;

    logic [12:0]       vertex_count_reg;
    logic [3:0]        table_bits_reg;
    logic [4:0]        key_words_reg;

    logic [31:0]       in_key_reg [MAX_KEY_WORDS];
    logic [WPOS_W-1:0] pos_reg, pos_next;
    logic              last_reg, last_next;
    logic [15:0]       src_reg, src_next;
    logic [CNT_W-1:0]  uc_reg, uc_next;
    logic [CLR_W-1:0]  clr_reg, clr_next;
    logic [SLOT_W-1:0] bucket_reg, bucket_next;
    logic [SLOT_W-1:0] probe_reg, probe_next;
    logic [WPOS_W-1:0] cnt_reg, cnt_next;
    logic [VTX_W-1:0]  slot_idx_reg, slot_idx_next;
    logic [VTX_W-1:0]  res_idx_reg, res_idx_next;
    logic [2:0]        res_st_reg, res_st_next;

    logic              out_valid_reg, out_valid_next;
    logic [VTX_W-1:0]  out_index_reg;
    logic [2:0]        status_reg;
    logic [CNT_W-1:0]  unique_count_reg;

    logic [31:0]       key_mem [1 << KADR_W];
    logic [VTX_W:0]    meta_mem [TABLE_SLOTS];
    logic [VTX_W:0]    remap_mem [MAX_VERTICES];

    logic              key_we;
    logic [KADR_W-1:0] key_addr;
    logic [31:0]       key_q;
    logic              meta_we;
    logic [SLOT_W-1:0] meta_addr;
    logic [VTX_W:0]    meta_wdata;
    logic [VTX_W:0]    meta_q;
    logic              remap_we;
    logic [VTX_W-1:0]  remap_addr;
    logic [VTX_W:0]    remap_wdata;
    logic [VTX_W:0]    remap_q;

    hash_ctl_t         hctl;
    hash_stat_t        hstat;
    logic [31:0]       hash;

    logic              accept;
    logic              out_free;
    logic              word_last;
    logic              key_eq;
    logic [KW_W-1:0]   kw_eff;
    logic [WPOS_W-1:0] kw_last;
    logic [3:0]        tb_eff;
    logic [SLOT_W-1:0] mask;
    logic [12:0]       vc_eff;
    logic [SLOT_W:0]   step_sum;

    vwd_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (hctl),
        .word  (key_word),
        .stat  (hstat),
        .hash  (hash)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= 13'd4096;
            table_bits_reg   <= 4'd13;
            key_words_reg    <= 5'd3;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_VERTEX_COUNT: vertex_count_reg <= cfg_data;
                CFG_TABLE_BITS:   table_bits_reg   <= cfg_data[3:0];
                CFG_KEY_WORDS:    key_words_reg    <= cfg_data[4:0];
                default:          ;
            endcase
        end
    end

    // Clamp the registers to what the tables hold
    always_comb
    begin
        kw_eff = key_words_reg;
        if (key_words_reg == '0)
        begin
            kw_eff = KW_W'(1);
        end
        else if (key_words_reg > KW_W'(MAX_KEY_WORDS))
        begin
            kw_eff = KW_W'(MAX_KEY_WORDS);
        end
        tb_eff = (table_bits_reg > 4'(SLOT_W)) ? 4'(SLOT_W) : table_bits_reg;
        vc_eff = (vertex_count_reg > 13'(MAX_VERTICES)) ? 13'(MAX_VERTICES)
                                                         : vertex_count_reg;
    end

    assign kw_last   = WPOS_W'(kw_eff - KW_W'(1));
    assign mask      = SLOT_W'(((SLOT_W + 1)'(1) << tb_eff) - (SLOT_W + 1)'(1));
    assign word_last = ({1'b0, pos_reg} + KW_W'(1)) >= kw_eff;
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign key_eq    = key_q == in_key_reg[cnt_reg];
    assign step_sum  = {1'b0, bucket_reg} + {1'b0, probe_reg} + (SLOT_W + 1)'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == CLR_W'(TABLE_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (action == ACT_CLEAR) ? S_CLEAR : S_HASH;
                end
            end
            S_HASH:
            begin
                if (hstat.done)
                begin
                    state_next = last_reg ? S_LOOKUP : S_IDLE;
                end
            end
            S_LOOKUP:
            begin
                state_next = (src_reg >= 16'(vc_eff)) ? S_RESULT : S_REMAP_CHK;
            end
            S_REMAP_CHK:
            begin
                state_next = remap_q[VTX_W] ? S_RESULT : S_META_RD;
            end
            S_META_RD:
            begin
                state_next = S_META_CHK;
            end
            S_META_CHK:
            begin
                if (meta_q[VTX_W])
                begin
                    state_next = S_KEY_RD;
                end
                else
                begin
                    state_next = (uc_reg < CNT_W'(MAX_VERTICES)) ? S_COPY : S_RESULT;
                end
            end
            S_KEY_RD:
            begin
                state_next = S_KEY_CHK;
            end
            S_KEY_CHK:
            begin
                if (key_eq)
                begin
                    state_next = (cnt_reg == kw_last) ? S_RESULT : S_KEY_RD;
                end
                else
                begin
                    state_next = (probe_reg == mask) ? S_RESULT : S_META_RD;
                end
            end
            S_COPY:
            begin
                if (cnt_reg == kw_last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall       = state_reg != S_IDLE;
        hctl           = '0;
        pos_next       = pos_reg;
        last_next      = last_reg;
        src_next       = src_reg;
        uc_next        = uc_reg;
        clr_next       = clr_reg;
        bucket_next    = bucket_reg;
        probe_next     = probe_reg;
        cnt_next       = cnt_reg;
        slot_idx_next  = slot_idx_reg;
        res_idx_next   = res_idx_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg && out_stall;
        key_we         = 1'b0;
        key_addr       = {bucket_reg, cnt_reg};
        meta_we        = 1'b0;
        meta_addr      = bucket_reg;
        meta_wdata     = {1'b1, uc_reg[VTX_W-1:0]};
        remap_we       = 1'b0;
        remap_addr     = src_reg[VTX_W-1:0];
        remap_wdata    = {1'b1, uc_reg[VTX_W-1:0]};
        case (state_reg)
            S_CLEAR:
            begin
                meta_we     = 1'b1;
                meta_addr   = clr_reg[SLOT_W-1:0];
                meta_wdata  = '0;
                remap_we    = clr_reg < CLR_W'(MAX_VERTICES);
                remap_addr  = clr_reg[VTX_W-1:0];
                remap_wdata = '0;
                clr_next    = clr_reg + CLR_W'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_CLEAR)
                    begin
                        hctl.clear = 1'b1;
                        pos_next   = '0;
                        uc_next    = '0;
                        clr_next   = '0;
                    end
                    else
                    begin
                        hctl.start = 1'b1;
                        hctl.last  = word_last;
                        last_next  = word_last;
                        src_next   = src_index;
                        pos_next   = word_last ? '0 : pos_reg + WPOS_W'(1);
                    end
                end
            end
            S_LOOKUP:
            begin
                res_st_next  = ST_RANGE;
                res_idx_next = '0;
            end
            S_REMAP_CHK:
            begin
                res_st_next  = ST_REPEAT;
                res_idx_next = remap_q[VTX_W-1:0];
                bucket_next  = hash[SLOT_W-1:0] & mask;
                probe_next   = '0;
            end
            S_META_CHK:
            begin
                cnt_next      = '0;
                slot_idx_next = meta_q[VTX_W-1:0];
                if (!meta_q[VTX_W])
                begin
                    res_st_next  = ST_FULL;
                    res_idx_next = '0;
                    if (uc_reg < CNT_W'(MAX_VERTICES))
                    begin
                        meta_we      = 1'b1;
                        remap_we     = 1'b1;
                        res_st_next  = ST_NEW;
                        res_idx_next = uc_reg[VTX_W-1:0];
                        uc_next      = uc_reg + CNT_W'(1);
                    end
                end
            end
            S_KEY_CHK:
            begin
                if (key_eq)
                begin
                    cnt_next = cnt_reg + WPOS_W'(1);
                    if (cnt_reg == kw_last)
                    begin
                        remap_we     = 1'b1;
                        remap_wdata  = {1'b1, slot_idx_reg};
                        res_st_next  = ST_MATCH;
                        res_idx_next = slot_idx_reg;
                    end
                end
                else
                begin
                    // Advance the triangular probe
                    res_st_next  = ST_FULL;
                    res_idx_next = '0;
                    bucket_next  = step_sum[SLOT_W-1:0] & mask;
                    probe_next   = probe_reg + SLOT_W'(1);
                end
            end
            S_COPY:
            begin
                key_we   = 1'b1;
                cnt_next = cnt_reg + WPOS_W'(1);
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            pos_reg       <= '0;
            uc_reg        <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            uc_reg        <= uc_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg     <= last_next;
        src_reg      <= src_next;
        bucket_reg   <= bucket_next;
        probe_reg    <= probe_next;
        cnt_reg      <= cnt_next;
        slot_idx_reg <= slot_idx_next;
        res_idx_reg  <= res_idx_next;
        res_st_reg   <= res_st_next;
        if (accept && action == ACT_WORD)
        begin
            in_key_reg[pos_reg] <= key_word;
        end
        if (state_reg == S_RESULT && out_free)
        begin
            out_index_reg    <= res_idx_reg;
            status_reg       <= res_st_reg;
            unique_count_reg <= uc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_addr] <= in_key_reg[cnt_reg];
        end
        key_q <= key_mem[key_addr];
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_addr] <= meta_wdata;
        end
        meta_q <= meta_mem[meta_addr];
    end

    always_ff @(posedge clk)
    begin
        if (remap_we)
        begin
            remap_mem[remap_addr] <= remap_wdata;
        end
        remap_q <= remap_mem[remap_addr];
    end

    assign out_valid    = out_valid_reg;
    assign out_index    = out_index_reg;
    assign status       = status_reg;
    assign unique_count = unique_count_reg;

endmodule

@@ src/vwd_hash.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex weld hash unit
// Chained word mix on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module vwd_hash (
    input  logic               clk,
    input  logic               rst_n,
    input  vwd_pkg::hash_ctl_t ctl,
    input  logic [31:0]        word,
    output vwd_pkg::hash_stat_t stat,
    output logic [31:0]        hash
);
    import vwd_pkg::*;

    logic [1:0]  step_reg, step_next;
    logic        run_reg, run_next;
    logic        last_reg, last_next;
    logic        done_reg, done_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] k_reg, k_next;
    logic [31:0] m_reg, m_next;
    logic [31:0] hash_reg, hash_next;
    logic [31:0] mul_a;
    logic [31:0] prod;
    logic [31:0] mixed;

    assign mixed = m_reg ^ k_reg;
    assign prod  = mul_a * MIX_M;

    always_comb
    begin
        mul_a = word;
        if (run_reg && step_reg == 2'd1)
        begin
            mul_a = k_reg ^ (k_reg >> MIX_R);
        end
        else if (run_reg && step_reg == 2'd2)
        begin
            mul_a = h_reg;
        end
    end

    always_comb
    begin
        step_next = step_reg;
        run_next  = run_reg;
        last_next = last_reg;
        done_next = 1'b0;
        h_next    = h_reg;
        k_next    = k_reg;
        m_next    = m_reg;
        hash_next = hash_reg;
        if (ctl.clear)
        begin
            h_next   = '0;
            run_next = 1'b0;
        end
        else if (ctl.start)
        begin
            k_next    = prod;
            last_next = ctl.last;
            run_next  = 1'b1;
            step_next = 2'd1;
        end
        else if (run_reg)
        begin
            case (step_reg)
                2'd1:
                begin
                    k_next    = prod;
                    step_next = 2'd2;
                end
                2'd2:
                begin
                    m_next    = prod;
                    step_next = 2'd3;
                end
                2'd3:
                begin
                    hash_next = mixed;
                    h_next    = last_reg ? 32'd0 : mixed;
                    done_next = 1'b1;
                    run_next  = 1'b0;
                    step_next = 2'd0;
                end
                default:
                begin
                    run_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            h_reg    <= '0;
        end
        else
        begin
            step_reg <= step_next;
            run_reg  <= run_next;
            done_reg <= done_next;
            h_reg    <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        k_reg    <= k_next;
        m_reg    <= m_next;
        hash_reg <= hash_next;
    end

    assign stat.done = done_reg;
    assign hash      = hash_reg;

endmodule

@@ src/vwd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex weld port checker
// Watches the result channel of the weld table for consistent items.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vwd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [11:0] out_index,
    input logic [2:0]  status,
    input logic [12:0] unique_count
);
    import vwd_pkg::*;

    logic        out_held;
    logic        res_flag;
    logic        res_new;
    logic        res_kept;
    logic [12:0] out_idx_ext;
    logic [27:0] payload;

    assign out_held    = out_valid && out_stall;
    assign res_flag    = out_valid && (status inside {ST_RANGE, ST_FULL});
    assign res_new     = out_valid && status == ST_NEW;
    assign res_kept    = out_valid && (status inside {ST_NEW, ST_MATCH, ST_REPEAT});
    assign out_idx_ext = {1'b0, out_index};
    assign payload     = {out_index, status, unique_count};

    `VWD_ASSERT_NEXT(a_out_hold, out_held, out_valid, "result item dropped")
    `VWD_ASSERT_NEXT(a_out_stable, out_held, $stable(payload), "stalled item changed")
    `VWD_ASSERT(a_flag_zero, res_flag |-> out_index == 12'd0, "flagged item has nonzero index")
    `VWD_ASSERT(a_new_last, res_new |-> out_idx_ext == unique_count - 13'd1, "new index not latest")
    `VWD_ASSERT(a_idx_bound, res_kept |-> out_idx_ext < unique_count, "index beyond unique count")

endmodule

bind vertex_weld_dedup_table vwd_checker u_vwd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_index    (out_index),
    .status       (status),
    .unique_count (unique_count)
);
